>>> rtl/tdpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpq_pkg
// Shared types and constants of the tail-drop packet queue.
// ----------------------------------------------------------------------------
package tdpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int BYTES_W     = 22;
  localparam int HANDLE_W    = 16;
  localparam int LENGTH_W    = 16;
  localparam int ENTRY_W     = HANDLE_W + LENGTH_W;
  localparam int MAXPKT_W    = 6;
  localparam int MAXBYTE_W   = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  // operation codes
  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_FLUSH   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_DEQUEUED = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FLUSHED  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKETS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES   = 2'd2;

  localparam logic [MAXPKT_W-1:0]  MAX_PACKETS_RST = 6'd63;
  localparam logic [MAXBYTE_W-1:0] MAX_BYTES_RST   = 20'd96000;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] packet_handle;
    logic [LENGTH_W-1:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic [LENGTH_W-1:0] out_length;
    logic [CNT_W-1:0]    queued_packets;
    logic [BYTES_W-1:0]  queued_bytes;
  } out_item_t;

endpackage

>>> rtl/tdpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpq_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tdpq_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tail_drop_packet_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tail_drop_packet_queue
// FIFO of packet descriptors with packet- or byte-limited tail drop.
// The result is registered in the cycle after the input transfer; a dequeue
// of a queued packet first passes through S_READ for the descriptor RAM read.
// One enqueue, flush or empty dequeue per cycle unless the output stalls; a
// queued dequeue stalls input in S_READ. Synchronous reset clears pointers
// and counters, restores default limits; the descriptor RAM is not cleared.
// ----------------------------------------------------------------------------
module tail_drop_packet_queue (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  tdpq_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tdpq_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tdpq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tdpq_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import tdpq_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [BYTES_W-1:0]   bytes_r, bytes_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic                 limit_mode_r;
  logic [MAXPKT_W-1:0]  max_packets_r;
  logic [MAXBYTE_W-1:0] max_bytes_r;

  logic                 in_xfer;
  logic                 admit;
  logic                 ram_we;
  logic                 ram_re;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [HANDLE_W-1:0]  rd_handle;
  logic [LENGTH_W-1:0]  rd_length;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  tdpq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W),
    .ADDR_W(PTR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata({in_data.packet_handle, in_data.packet_length}),
    .re   (ram_re),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  assign rd_handle = ram_rdata[ENTRY_W-1:LENGTH_W];
  assign rd_length = ram_rdata[LENGTH_W-1:0];

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mode_r  <= 1'b0;
      max_packets_r <= MAX_PACKETS_RST;
      max_bytes_r   <= MAX_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIMIT_MODE:  limit_mode_r  <= cfg_data[0];
        REG_MAX_PACKETS: max_packets_r <= cfg_data[MAXPKT_W-1:0];
        REG_MAX_BYTES:   max_bytes_r   <= cfg_data[MAXBYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
      admit = 1'b0;
    end else if (limit_mode_r) begin
      admit = bytes_r <= BYTES_W'(max_bytes_r);
    end else begin
      admit = count_r <= CNT_W'(max_packets_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    bytes_nxt     = bytes_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_handle = '0;
          out_data_nxt.out_length = '0;
          out_data_nxt.status     = ST_DROPPED;
          case (in_data.kind)
            KIND_ENQUEUE: begin
              if (admit) begin
                ram_we              = 1'b1;
                tail_nxt            = advance(tail_r);
                count_nxt           = count_r + 1'b1;
                bytes_nxt           = bytes_r + BYTES_W'(in_data.packet_length);
                out_data_nxt.status = ST_ACCEPTED;
              end
            end
            KIND_DEQUEUE: begin
              if (count_r == '0) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                ram_re        = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end
            end
            KIND_FLUSH: begin
              head_nxt            = '0;
              tail_nxt            = '0;
              count_nxt           = '0;
              bytes_nxt           = '0;
              out_data_nxt.status = ST_FLUSHED;
            end
            default: ;
          endcase
          out_data_nxt.queued_packets = count_nxt;
          out_data_nxt.queued_bytes   = bytes_nxt;
        end
      end
      S_READ: begin
        head_nxt                    = advance(head_r);
        count_nxt                   = count_r - 1'b1;
        bytes_nxt                   = bytes_r - BYTES_W'(rd_length);
        out_valid_nxt               = 1'b1;
        out_data_nxt.status         = ST_DEQUEUED;
        out_data_nxt.out_handle     = rd_handle;
        out_data_nxt.out_length     = rd_length;
        out_data_nxt.queued_packets = count_nxt;
        out_data_nxt.queued_bytes   = bytes_nxt;
        state_nxt                   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

endmodule
